>>> rtl/core/assert_macros.svh
// Assertion macros used by the top RTL module of the power sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

>>> rtl/core/dps_pkg.sv
// Shared constants, types and codes of the debounced power sequencer.
package dps_pkg;

  localparam int unsigned DECAY_W          = 8;
  localparam int unsigned THRESH_W         = 12;
  localparam int unsigned CFG_INDEX_W      = 8;
  localparam int unsigned CFG_DATA_W       = 12;
  localparam int unsigned IN_TDATA_W       = 8;
  localparam int unsigned OUT_TDATA_W      = 8;
  localparam int unsigned FILTER_WIDTH_DEF = 13;
  localparam int unsigned FILTER_RESET     = 2560;
  localparam int unsigned INPUT_STEP       = 256;

  localparam logic [DECAY_W-1:0]  DECAY_RESET  = 8'd230;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 12'd1280;

  localparam logic [CFG_INDEX_W-1:0] REG_DECAY  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_THRESH = 8'd1;

  localparam logic [1:0] PS_SLEEP  = 2'd0;
  localparam logic [1:0] PS_BOOT   = 2'd1;
  localparam logic [1:0] PS_ONLINE = 2'd2;

  typedef enum logic [2:0] {
    ST_SLEEP  = 3'b001,
    ST_BOOT   = 3'b010,
    ST_ONLINE = 3'b100
  } seq_state_t;

  // Packed so that the last result field, boost_on, lands in bit 0.
  typedef struct packed {
    logic [1:0] power_state;
    logic       online_level;
    logic       button_toggled;
    logic       button_level;
    logic       forwarded_button;
    logic       boost_on;
  } result_t;

endpackage

>>> rtl/core/dps_ema_filter.sv
// Exponential moving average filter with saturation and level compare.
module dps_ema_filter #(
  parameter int unsigned FILTER_WIDTH = dps_pkg::FILTER_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step_en,
  input  logic                          sample_bit,
  input  logic [dps_pkg::DECAY_W-1:0]   decay_q8,
  input  logic [dps_pkg::THRESH_W-1:0]  level_threshold,
  output logic                          level_nxt
);
  import dps_pkg::*;

  localparam int unsigned PROD_W  = FILTER_WIDTH + DECAY_W;
  localparam int unsigned SUM_W   = FILTER_WIDTH + 1;
  localparam int unsigned CMP_W   = (FILTER_WIDTH > THRESH_W) ? FILTER_WIDTH : THRESH_W;
  localparam int unsigned MAX_INT = (1 << (FILTER_WIDTH - 1)) - 1;
  localparam int unsigned RST_INT = (FILTER_RESET > MAX_INT) ? MAX_INT : FILTER_RESET;
  localparam logic [FILTER_WIDTH-1:0] AVG_MAX   = FILTER_WIDTH'(MAX_INT);
  localparam logic [FILTER_WIDTH-1:0] AVG_RESET = FILTER_WIDTH'(RST_INT);

  logic [FILTER_WIDTH-1:0] avg_r;
  logic [FILTER_WIDTH-1:0] avg_nxt;
  logic [PROD_W-1:0]       product;
  logic [FILTER_WIDTH-1:0] scaled;
  logic [SUM_W-1:0]        sum;

  assign product = PROD_W'(avg_r) * PROD_W'(decay_q8);
  assign scaled  = product[PROD_W-1:DECAY_W];
  assign sum     = SUM_W'(scaled) + (sample_bit ? SUM_W'(INPUT_STEP) : SUM_W'(0));
  assign avg_nxt = (sum > SUM_W'(AVG_MAX)) ? AVG_MAX : sum[FILTER_WIDTH-1:0];

  assign level_nxt = CMP_W'(avg_nxt) > CMP_W'(level_threshold);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r <= AVG_RESET;
    end else if (step_en) begin
      avg_r <= avg_nxt;
    end
  end

endmodule

>>> rtl/core/debounced_power_sequencer.sv
// Top level of the debounced power sequencer: filters, sequencer, output buffer.
//
// Each transfer on the in_ channel is one timer tick carrying the raw button
// (in_tdata[0], 0 pressed) and raw online (in_tdata[1]) samples. Each tick
// updates two averaging filters, the debounced levels and the three-state
// power sequencer, and yields exactly one result transfer on the out_ channel.
// A tick's result is registered into out_, or into the skid register while
// out_ is stalled. Throughput is one tick per cycle while in_tready is high;
// the filter multiply, saturation and threshold compare plus the sequencer
// step form the single combinational stage ahead of the result register.
// A two-entry output buffer (result register plus skid register) lets one
// more tick in while a result is stalled; with both full, in_tready drops
// until the receiver takes a result. Order of results is always kept.
// The cfg_ channel writes decay_q8 (index 0) and level_threshold (index 1);
// other indexes are ignored. cfg_ready is always high.
// Synchronous reset restores the default registers, sets both averages to
// 10.0 in Q.8 (clamped to the filter maximum), the button level high, the
// sequencer to sleep and empties the output buffer.
`include "assert_macros.svh"

module debounced_power_sequencer #(
  parameter int unsigned FILTER_WIDTH = dps_pkg::FILTER_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // tdata: [0] raw_button, [1] raw_online, [7:2] zero
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [dps_pkg::IN_TDATA_W-1:0]  in_tdata,
  // tdata: [0] boost_on, [1] forwarded_button, [2] button_level,
  // [3] button_toggled, [4] online_level, [6:5] power_state, [7] zero
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [dps_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dps_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import dps_pkg::*;

  logic [DECAY_W-1:0]  decay_r;
  logic [THRESH_W-1:0] thresh_r;

  seq_state_t state_r, state_nxt;
  logic       boost_r, boost_nxt;
  logic       fwd_r, fwd_nxt;
  logic       btn_level_r;
  logic       prev_raw_r;

  logic       in_fire;
  logic       raw_button, raw_online;
  logic       btn_level_nxt, online_level_nxt;
  logic       falling;
  logic [1:0] power_code;
  result_t    new_res;

  result_t    out_r, skid_r;
  logic       out_valid_r, skid_valid_r;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !skid_valid_r;
  assign in_fire    = in_tvalid && in_tready;
  assign raw_button = in_tdata[0];
  assign raw_online = in_tdata[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_r  <= DECAY_RESET;
      thresh_r <= THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_DECAY) begin
        decay_r <= cfg_data[DECAY_W-1:0];
      end else if (cfg_index == REG_THRESH) begin
        thresh_r <= cfg_data[THRESH_W-1:0];
      end
    end
  end

  dps_ema_filter #(.FILTER_WIDTH(FILTER_WIDTH)) u_button_filter (
    .clk             (clk),
    .rst_n           (rst_n),
    .step_en         (in_fire),
    .sample_bit      (raw_button),
    .decay_q8        (decay_r),
    .level_threshold (thresh_r),
    .level_nxt       (btn_level_nxt)
  );

  dps_ema_filter #(.FILTER_WIDTH(FILTER_WIDTH)) u_online_filter (
    .clk             (clk),
    .rst_n           (rst_n),
    .step_en         (in_fire),
    .sample_bit      (raw_online),
    .decay_q8        (decay_r),
    .level_threshold (thresh_r),
    .level_nxt       (online_level_nxt)
  );

  assign falling = prev_raw_r && !raw_button;

  always_comb begin
    state_nxt = state_r;
    boost_nxt = boost_r;
    fwd_nxt   = fwd_r;
    case (state_r)
      ST_SLEEP: begin
        boost_nxt = 1'b0;
        fwd_nxt   = 1'b0;
        if (falling) begin
          boost_nxt = 1'b1;
          state_nxt = ST_BOOT;
        end
      end
      ST_BOOT: begin
        fwd_nxt = btn_level_nxt;
        if (online_level_nxt) begin
          state_nxt = ST_ONLINE;
        end
      end
      ST_ONLINE: begin
        fwd_nxt = btn_level_nxt;
        if (!online_level_nxt) begin
          boost_nxt = 1'b0;
          state_nxt = ST_SLEEP;
        end
      end
      default: begin
        state_nxt = ST_SLEEP;
      end
    endcase
  end

  always_comb begin
    case (state_nxt)
      ST_SLEEP:  power_code = PS_SLEEP;
      ST_BOOT:   power_code = PS_BOOT;
      ST_ONLINE: power_code = PS_ONLINE;
      default:   power_code = PS_SLEEP;
    endcase
  end

  always_comb begin
    new_res.boost_on         = boost_nxt;
    new_res.forwarded_button = fwd_nxt;
    new_res.button_level     = btn_level_nxt;
    new_res.button_toggled   = btn_level_nxt != btn_level_r;
    new_res.online_level     = online_level_nxt;
    new_res.power_state      = power_code;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SLEEP;
      boost_r     <= 1'b0;
      fwd_r       <= 1'b0;
      btn_level_r <= 1'b1;
      prev_raw_r  <= 1'b1;
    end else if (in_fire) begin
      state_r     <= state_nxt;
      boost_r     <= boost_nxt;
      fwd_r       <= fwd_nxt;
      btn_level_r <= btn_level_nxt;
      prev_raw_r  <= raw_button;
    end
  end

  // The skid register only fills while the result register is stalled, and
  // it drains into the result register before any new tick is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r  <= skid_valid_r || in_fire;
      skid_valid_r <= 1'b0;
    end else if (in_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      out_r <= skid_valid_r ? skid_r : new_res;
    end else if (in_fire) begin
      skid_r <= new_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_r);

  `ASSERT_NEVER(a_skid_without_result, clk, rst_n, skid_valid_r && !out_valid_r)
  `ASSERT_PROP(a_boost_follows_state, clk, rst_n, boost_r == (state_r != ST_SLEEP))
  `ASSERT_PROP(a_skid_fills_on_stall, clk, rst_n, $rose(skid_valid_r) |-> $past(out_valid_r && !out_tready))

endmodule
